### hdl/mpq_pkg.sv
// Shared types and codes for the max-priority queue.
package mpq_pkg;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam int DataW = 32;
   localparam int PrioW = 16;
   localparam int OccW  = 7;

   // One queue entry as held by a cell.
   typedef struct packed {
      logic                    valid;
      logic signed [DataW-1:0] data;
      logic signed [PrioW-1:0] prio;
   } entry_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage

### hdl/mpq_cell.sv
// One storage cell of the sorted shift array.
module mpq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  mpq_pkg::cell_ctrl_type ctrl,
   input  mpq_pkg::entry_type    new_entry,
   input  mpq_pkg::entry_type    left_entry,
   input  logic                  left_less,
   input  mpq_pkg::entry_type    right_entry,
   output mpq_pkg::entry_type    entry,
   output logic                  less
);
   import mpq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // An empty cell counts as lower than any new entry; an equal priority stays
   // ahead so that earlier arrivals leave first.
   assign less  = !entry_ff.valid || (entry_ff.prio < new_entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.remove) begin
         entry_in = right_entry;
      end else if (ctrl.insert && less) begin
         if (left_less) begin
            entry_in = left_entry;
         end else begin
            entry_in = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff.data <= entry_in.data;
      entry_ff.prio <= entry_in.prio;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

endmodule

### hdl/max_priority_queue.sv
// Top level of the bounded max-priority queue built from a chain of sorted cells.
//
// The queue holds up to DEPTH (data, priority) entries in a row of cells kept
// sorted by signed priority, highest at the head, with entries of equal
// priority kept in arrival order. An insert or a remove is accepted on any
// rising clock edge where start is high and busy is low; busy is never raised,
// so one operation can be accepted on every clock. The result appears on the
// rsp_ ports in the cycle right after the accepting edge, marked by a
// one-cycle rsp_strobe pulse, and the receiver cannot stall it. This is set
// by the cell row: every cell compares its own priority with the
// incoming one in parallel and, in the same cycle, keeps its entry, takes the
// new entry, or takes its neighbor's entry, so an insert ripples the lower
// entries down one place and a remove shifts every entry up one place toward
// the head. An insert into a full queue reports full and a remove from an
// empty queue reports empty, both leaving the queue unchanged with zero
// removed fields. Every result carries the occupancy after the operation,
// its low seven bits when DEPTH exceeds 127.
module max_priority_queue #(
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_operation,
   input  logic signed [mpq_pkg::DataW-1:0]      req_item_data,
   input  logic signed [mpq_pkg::PrioW-1:0]      req_item_priority,
   output logic                                  rsp_strobe,
   output logic [1:0]                            rsp_status,
   output logic signed [mpq_pkg::DataW-1:0]      rsp_removed_data,
   output logic signed [mpq_pkg::PrioW-1:0]      rsp_removed_priority,
   output logic [mpq_pkg::OccW-1:0]              rsp_occupancy
);
   import mpq_pkg::*;

   localparam int CountW = $clog2(DEPTH + 1);

   // Cell row wiring.
   entry_type     cell_entry [DEPTH];
   logic          cell_less  [DEPTH];
   entry_type     new_entry;
   entry_type     tail_entry;
   cell_ctrl_type ctrl;

   // Occupancy counter and registered result.
   logic [CountW-1:0]       count_ff;
   logic [CountW-1:0]       count_in;
   logic                    strobe_ff;
   status_type              status_ff;
   status_type              status_in;
   logic signed [DataW-1:0] rdata_ff;
   logic signed [DataW-1:0] rdata_in;
   logic signed [PrioW-1:0] rprio_ff;
   logic signed [PrioW-1:0] rprio_in;
   logic [OccW-1:0]         occ_ff;
   logic [CountW+OccW-1:0]  occ_wide;

   logic accept;
   logic full;
   logic empty;

   // The cell row finishes any operation at the accepting edge, so no transfer is
   // ever held off.
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == CountW'(DEPTH));
   assign empty  = (count_ff == '0);

   assign new_entry.valid = 1'b1;
   assign new_entry.data  = req_item_data;
   assign new_entry.prio  = req_item_priority;

   // Shifting past the last cell brings in an empty slot.
   assign tail_entry.valid = 1'b0;
   assign tail_entry.data  = '0;
   assign tail_entry.prio  = '0;

   assign ctrl.insert = accept && (req_operation == OP_INSERT) && !full;
   assign ctrl.remove = accept && (req_operation == OP_REMOVE) && !empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_less;

      if (i == 0) begin : g_head
         // The head has no left neighbor: a new entry lower than nothing ahead
         // of it lands here directly.
         assign left_entry = new_entry;
         assign left_less  = 1'b0;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_less  = cell_less[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = tail_entry;
      end else begin : g_mid
         assign right_entry = cell_entry[i+1];
      end

      mpq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_entry  (new_entry),
         .left_entry (left_entry),
         .left_less  (left_less),
         .right_entry(right_entry),
         .entry      (cell_entry[i]),
         .less       (cell_less[i])
      );
   end

   // Result of the operation being accepted this cycle, taken from the state
   // before the cells update.
   always_comb begin
      count_in  = count_ff;
      status_in = ST_DONE;
      rdata_in  = '0;
      rprio_in  = '0;
      if (req_operation == OP_INSERT) begin
         if (full) begin
            status_in = ST_FULL;
         end else begin
            count_in = count_ff + CountW'(1);
         end
      end else begin
         if (empty) begin
            status_in = ST_EMPTY;
         end else begin
            // The head cell always holds the highest, earliest entry.
            rdata_in = cell_entry[0].data;
            rprio_in = cell_entry[0].prio;
            count_in = count_ff - CountW'(1);
         end
      end
   end

   assign occ_wide = {{OccW{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         status_ff <= ST_DONE;
         rdata_ff  <= '0;
         rprio_ff  <= '0;
         occ_ff    <= '0;
      end else begin
         strobe_ff <= accept;
         if (accept) begin
            count_ff  <= count_in;
            status_ff <= status_in;
            rdata_ff  <= rdata_in;
            rprio_ff  <= rprio_in;
            occ_ff    <= occ_wide[OccW-1:0];
         end
      end
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_status           = status_ff;
   assign rsp_removed_data     = rdata_ff;
   assign rsp_removed_priority = rprio_ff;
   assign rsp_occupancy        = occ_ff;

   // The head cell is occupied exactly when the count says the queue is not
   // empty.
   a_head_matches_count : assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) == cell_entry[0].valid)
      else $error("head cell validity disagrees with occupancy count");

   // The last cell is occupied exactly when the queue is full.
   a_tail_matches_full : assert property (@(posedge clock) disable iff (reset)
      full == cell_entry[DEPTH-1].valid)
      else $error("tail cell validity disagrees with full flag");

   // Every accepted operation produces a result strobe in the next cycle.
   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted operation produced no result");

   // An empty report leaves the queue empty.
   a_empty_report : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_EMPTY) |-> (count_ff == '0))
      else $error("empty reported while entries are held");

   // A full report leaves the queue full.
   a_full_report : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_FULL) |-> full)
      else $error("full reported while room remains");

endmodule
